[src/sync_length_crc_frame_parser_top_assert.svh]
// Assertion macros for the sync/length/CRC frame parser.
// Used by the top level only; no other dependencies.
`ifndef SYNC_LENGTH_CRC_FRAME_PARSER_TOP_ASSERT_SVH
`define SYNC_LENGTH_CRC_FRAME_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SLFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/slfp_pkg.sv]
// Shared constants, types and the CRC byte-step function of the frame parser.
// No dependencies.
package slfp_pkg;

   localparam logic [7:0]  SYNC_FIRST  = 8'h48;
   localparam logic [7:0]  SYNC_SECOND = 8'h5A;
   localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;

   // one fold of a 32-bit word takes four byte steps
   localparam int          FOLD_STEPS  = 4;
   localparam int          FOLD_CNT_W  = 3;
   localparam logic [3:0]  WORD_BYTES  = 4'd8;

   typedef struct packed {
      logic        init;
      logic        start;
      logic [31:0] word;
   } crc_cmd_type;

   // eight MSB-first shift steps of the CRC register, no data input
   function automatic logic [31:0] crc_shift8(input logic [31:0] c);
      logic [31:0] r;
      r = c;
      for (int k = 0; k < 8; k++) begin
         r = r[31] ? ({r[30:0], 1'b0} ^ CRC_POLY) : {r[30:0], 1'b0};
      end
      return r;
   endfunction

endpackage

[src/slfp_crc.sv]
// Iterative CRC-32 folding unit: folds one 32-bit word byte by byte, 8 shift steps per byte.
// Depends on slfp_pkg.
module slfp_crc (
   input  logic                 clock,
   input  logic                 reset,
   input  slfp_pkg::crc_cmd_type cmd,
   output logic [31:0]          crc_value,
   output logic                 busy
);
   import slfp_pkg::*;

   logic [31:0]           crc_ff, crc_in;
   logic [FOLD_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      crc_in = crc_ff;
      cnt_in = cnt_ff;
      if (cmd.init) begin
         crc_in = CRC_INIT;
         cnt_in = '0;
      end else if (cmd.start) begin
         // mix the word in and take the first byte step at once
         crc_in = crc_shift8(crc_ff ^ cmd.word);
         cnt_in = FOLD_CNT_W'(FOLD_STEPS - 1);
      end else if (cnt_ff != '0) begin
         crc_in = crc_shift8(crc_ff);
         cnt_in = cnt_ff - FOLD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
         cnt_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign crc_value = crc_ff;
   assign busy      = (cnt_ff != '0);

endmodule

[src/slfp_pay_ram.sv]
// Payload byte store: one write port, one read port, registered read data.
// No package dependencies.
module slfp_pay_ram #(
   parameter int DEPTH  = 255,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/sync_length_crc_frame_parser_top.sv]
// Top level of the sync/length framed receiver with CRC-32 check byte.
// Depends on slfp_pkg, slfp_crc, slfp_pay_ram and the assertion macro header.
//
//   channel   direction  ports                                 beat
//   req       in         req_valid req_stall req_rx_byte        one received byte
//   rsp       out        rsp_valid rsp_stall rsp_payload_word   one payload word or
//                        rsp_byte_count rsp_last_word ...       one mismatch status
//
// Flow: a byte that completes a 32-bit CRC word holds off the next byte while the
//   byte-per-cycle CRC folding unit takes its byte steps. After the check byte the
//   close state folds a partial word and, for a short frame, one zero pad word, then
//   leaves for the check state. Readout gathers each 8-byte word with one payload-store
//   read a cycle, then emits it once the output register is free; an empty payload gives one beat.
// Reset: synchronous, active high; back to hunting for the first sync byte. The
//   payload store has no reset and needs no clearing pass.
// Stalls: rsp_stall holds the output register and the readout; the next byte is
//   taken as soon as the last word of a frame sits in the output register.
`include "sync_length_crc_frame_parser_top_assert.svh"

module sync_length_crc_frame_parser_top #(
   parameter int MAX_PAYLOAD = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_payload_word,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_last_word,
   output logic        rsp_frame_status,
   output logic [7:0]  rsp_computed_check,
   output logic [7:0]  rsp_received_check
);
   import slfp_pkg::*;

   localparam int         ADDR_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);

   typedef enum logic [1:0] {
      PH_HUNT_H,
      PH_HUNT_Z,
      PH_LENGTH,
      PH_COLLECT
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_CHECK,
      ST_READ
   } state_type;

   // parser and control state
   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  len_ff, len_in;
   logic [8:0]  seen_ff, seen_in;
   logic [31:0] gather_ff, gather_in;
   logic [7:0]  chk_ff, chk_in;
   logic        part_ff, part_in;
   logic        pad_ff, pad_in;

   // readout
   logic [8:0]  pos_ff, pos_in;
   logic [3:0]  iss_ff, iss_in;
   logic        pend_ff, pend_in;
   logic [2:0]  plane_ff, plane_in;
   logic [63:0] wbuf_ff, wbuf_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_word_ff, rsp_word_in;
   logic [3:0]  rsp_count_ff, rsp_count_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_comp_ff, rsp_comp_in;
   logic [7:0]  rsp_recv_ff, rsp_recv_in;

   // unit connections
   crc_cmd_type       crc_cmd;
   logic [31:0]       crc_value;
   logic              crc_busy;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   logic        req_accept;
   logic        out_free;
   logic        take_en;
   logic [31:0] gather_take;
   logic [8:0]  len_ext;
   logic        rd_more;

   slfp_crc u_crc (
      .clock     (clock),
      .reset     (reset),
      .cmd       (crc_cmd),
      .crc_value (crc_value),
      .busy      (crc_busy)
   );

   slfp_pay_ram #(
      .DEPTH  (MAX_PAYLOAD),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Writes happen only while collecting and reads only after the check byte,
   // so the store never sees a read and a write of one entry at once.
   assign req_stall   = (state_ff != ST_IDLE) || crc_busy;
   assign req_accept  = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign len_ext     = {1'b0, len_ff};
   assign gather_take = gather_ff | ({24'b0, req_rx_byte} << {seen_ff[1:0], 3'b000});
   assign wr_addr     = ADDR_W'(seen_ff - 9'd3);
   assign rd_addr     = pos_ff[ADDR_W-1:0];
   assign rd_more     = (iss_ff < WORD_BYTES) && (pos_ff < len_ext);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      len_in        = len_ff;
      seen_in       = seen_ff;
      gather_in     = gather_ff;
      chk_in        = chk_ff;
      part_in       = part_ff;
      pad_in        = pad_ff;
      pos_in        = pos_ff;
      iss_in        = iss_ff;
      pend_in       = pend_ff;
      plane_in      = plane_ff;
      wbuf_in       = wbuf_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_comp_in   = rsp_comp_ff;
      rsp_recv_in   = rsp_recv_ff;
      crc_cmd       = '0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      take_en       = 1'b0;

      // drop the output beat once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (phase_ff)
                  PH_HUNT_H: begin
                     if (req_rx_byte == SYNC_FIRST) begin
                        // fresh frame: restart CRC, first byte lands in lane 0
                        crc_cmd.init = 1'b1;
                        len_in       = '0;
                        seen_in      = 9'd1;
                        gather_in    = {24'b0, req_rx_byte};
                        phase_in     = PH_HUNT_Z;
                     end
                  end
                  PH_HUNT_Z: begin
                     if (req_rx_byte == SYNC_SECOND) begin
                        take_en  = 1'b1;
                        phase_in = PH_LENGTH;
                     end else begin
                        phase_in = PH_HUNT_H;
                     end
                  end
                  PH_LENGTH: begin
                     if ({1'b0, req_rx_byte} > MAX_LEN) begin
                        phase_in = PH_HUNT_H;
                     end else begin
                        len_in   = req_rx_byte;
                        take_en  = 1'b1;
                        phase_in = PH_COLLECT;
                     end
                  end
                  PH_COLLECT: begin
                     if (seen_ff < len_ext + 9'd3) begin
                        wr_en   = 1'b1;
                        take_en = 1'b1;
                     end else begin
                        // check byte: close with the partial word and pad to two words
                        chk_in   = req_rx_byte;
                        part_in  = (seen_ff[1:0] != 2'd0);
                        pad_in   = (seen_ff < 9'd5);
                        phase_in = PH_HUNT_H;
                        state_in = ST_CLOSE;
                     end
                  end
                  default: begin
                     phase_in = PH_HUNT_H;
                  end
               endcase
            end
         end
         ST_CLOSE: begin
            if (!crc_busy) begin
               if (part_ff) begin
                  crc_cmd.start = 1'b1;
                  crc_cmd.word  = gather_ff;
                  gather_in     = '0;
                  part_in       = 1'b0;
               end else if (pad_ff) begin
                  crc_cmd.start = 1'b1;
                  crc_cmd.word  = '0;
                  pad_in        = 1'b0;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (crc_value[7:0] != chk_ff) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_word_in   = '0;
                  rsp_count_in  = '0;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = 1'b1;
                  rsp_comp_in   = crc_value[7:0];
                  rsp_recv_in   = chk_ff;
                  state_in      = ST_IDLE;
               end
            end else begin
               pos_in   = '0;
               iss_in   = '0;
               pend_in  = 1'b0;
               wbuf_in  = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // land the byte read last cycle
            if (pend_ff) begin
               wbuf_in[{plane_ff, 3'b000} +: 8] = rd_data;
            end
            if (rd_more) begin
               rd_en    = 1'b1;
               pos_in   = pos_ff + 9'd1;
               iss_in   = iss_ff + 4'd1;
               pend_in  = 1'b1;
               plane_in = iss_ff[2:0];
            end else begin
               pend_in = 1'b0;
               if (!pend_ff && out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_word_in   = wbuf_ff;
                  rsp_count_in  = iss_ff;
                  rsp_last_in   = (pos_ff >= len_ext);
                  rsp_status_in = 1'b0;
                  rsp_comp_in   = crc_value[7:0];
                  rsp_recv_in   = chk_ff;
                  wbuf_in       = '0;
                  iss_in        = '0;
                  if (pos_ff >= len_ext) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // gather one CRC byte; fold when the word fills
      if (take_en) begin
         seen_in = seen_ff + 9'd1;
         if (seen_ff[1:0] == 2'd3) begin
            crc_cmd.start = 1'b1;
            crc_cmd.word  = gather_take;
            gather_in     = '0;
         end else begin
            gather_in = gather_take;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_HUNT_H;
         len_ff       <= '0;
         seen_ff      <= '0;
         gather_ff    <= '0;
         part_ff      <= 1'b0;
         pad_ff       <= 1'b0;
         pos_ff       <= '0;
         iss_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         gather_ff    <= gather_in;
         part_ff      <= part_in;
         pad_ff       <= pad_in;
         pos_ff       <= pos_in;
         iss_ff       <= iss_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_ff        <= chk_in;
      plane_ff      <= plane_in;
      wbuf_ff       <= wbuf_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_comp_ff   <= rsp_comp_in;
      rsp_recv_ff   <= rsp_recv_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_word   = rsp_word_ff;
   assign rsp_byte_count     = rsp_count_ff;
   assign rsp_last_word      = rsp_last_ff;
   assign rsp_frame_status   = rsp_status_ff;
   assign rsp_computed_check = rsp_comp_ff;
   assign rsp_received_check = rsp_recv_ff;

   // a fold in flight must hold off the next byte
   `SLFP_ASSERT_NOW(a_fold_stalls, clock, reset, crc_busy, req_stall,
      "byte taken during CRC fold")
   // a mismatch beat is a lone empty closing beat
   `SLFP_ASSERT_NOW(a_mismatch_shape, clock, reset, rsp_valid && rsp_frame_status,
      rsp_last_word && rsp_byte_count == 4'd0 && rsp_payload_word == 64'd0,
      "bad mismatch beat")
   // only the closing word of a frame may be short
   `SLFP_ASSERT_NOW(a_full_inner, clock, reset, rsp_valid && !rsp_last_word,
      rsp_byte_count == WORD_BYTES, "short inner payload word")
   // a failed check with room in the output register shows up next cycle
   `SLFP_ASSERT_NEXT(a_mismatch_out, clock, reset,
      state_ff == ST_CHECK && crc_value[7:0] != chk_ff && out_free,
      rsp_valid && rsp_frame_status && state_ff == ST_IDLE, "mismatch not reported")

endmodule
